### design/rbsi_pkg.sv
// shared constants for the ray/box slab test
package rbsi_pkg;
	localparam int CfgAddrWidth = 1;
	localparam logic [CfgAddrWidth-1:0] RegParallelThreshold = 1'b0;
	localparam int ThrWidth = 17;
	localparam logic [ThrWidth-1:0] ThrReset = 17'd1;
endpackage

### design/rbsi_if.sv
// valid/ready channel carrying one item
interface rbsi_if #(parameter int W = 1) (input logic clk);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### design/rbsi_div.sv
// pipelined signed restoring divider, one quotient bit per stage
module rbsi_div #(
	parameter int NW = 48,
	parameter int DW = 32
) (
	input  logic clk,
	input  logic en,
	input  logic signed [NW-1:0] num,
	input  logic signed [DW-1:0] den,
	output logic signed [NW-1:0] quo
);
	logic [NW-1:0] q_s [NW+1];
	logic [NW-1:0] r_s [NW+1];
	logic [DW-1:0] d_s [NW+1];
	logic neg_s [NW+1];

	// stage 0 takes magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			q_s[0] <= num[NW-1] ? -num : num;
			r_s[0] <= '0;
			d_s[0] <= den[DW-1] ? -den : den;
			neg_s[0] <= num[NW-1] ^ den[DW-1];
		end
	end

	// one bit per stage
	for (genvar k = 0; k < NW; k++) begin : g_st
		logic [NW:0] rt;
		logic [NW:0] df;
		assign rt = {r_s[k], q_s[k][NW-1]};
		assign df = rt - {{(NW+1-DW){1'b0}}, d_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (!df[NW]) begin
					r_s[k+1] <= df[NW-1:0];
					q_s[k+1] <= {q_s[k][NW-2:0], 1'b1};
				end else begin
					r_s[k+1] <= rt[NW-1:0];
					q_s[k+1] <= {q_s[k][NW-2:0], 1'b0};
				end
				d_s[k+1] <= d_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	assign quo = neg_s[NW] ? -q_s[NW] : q_s[NW];
endmodule

### design/ray_box_slab_intersect.sv
// ray versus axis-aligned box test, slab method, Q16.16 fixed point
// throughput: one item per cycle while the output is not stalled; three divider pairs pipelined a bit per stage
// the whole pipe advances together; a stall at the output holds every stage
// reset clears valid bits and sets parallel_threshold to 1
module ray_box_slab_intersect #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	rbsi_if.sink   in_ch,
	rbsi_if.source out_ch,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [rbsi_pkg::CfgAddrWidth+1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import rbsi_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int NW = COORD_WIDTH + FRAC_BITS + 1;
	localparam int DL = NW + 1;
	localparam int PW = 2 * CW;
	localparam logic signed [NW-1:0] QMAXW = NW'((64'sd1 <<< (CW-1)) - 1);
	localparam logic signed [NW-1:0] QMINW = -QMAXW - 1;
	localparam logic signed [CW-1:0] QMAX = {1'b0, {(CW-1){1'b1}}};
	localparam int LAT = DL + 5;

	typedef logic signed [CW-1:0] c_t;

	// configuration register
	logic [ThrWidth-1:0] thr_q;
	assign pready = 1'b1;
	assign prdata = (paddr[CfgAddrWidth+1:2] == RegParallelThreshold)
		? {{(32-ThrWidth){1'b0}}, thr_q} : '0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= ThrReset;
		else if (psel && penable && pwrite
			&& paddr[CfgAddrWidth+1:2] == RegParallelThreshold)
			thr_q <= pwdata[ThrWidth-1:0];
	end

	// global advance
	logic en;
	logic [LAT-1:0] v_q;
	assign en = !v_q[LAT-1] || out_ch.ready;
	assign in_ch.ready = en;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[LAT-2:0], in_ch.valid};
	end

	// unpack input item
	c_t o [3], d [3], lo [3], hi [3];
	for (genvar a = 0; a < 3; a++) begin : g_in
		assign o[a]  = in_ch.data[(12-a)*CW-1 -: CW];
		assign d[a]  = in_ch.data[(9-a)*CW-1 -: CW];
		assign lo[a] = in_ch.data[(6-a)*CW-1 -: CW];
		assign hi[a] = in_ch.data[(3-a)*CW-1 -: CW];
	end

	// stage 1: differences, parallel flags, slab containment
	logic signed [NW-1:0] n1_s1 [3], n2_s1 [3];
	c_t d_s1 [3], o_s1 [3];
	logic par_s1 [3], out_s1 [3];
	for (genvar a = 0; a < 3; a++) begin : g_s1
		logic signed [CW:0] mg;
		assign mg = d[a][CW-1] ? -(CW+1)'(d[a]) : (CW+1)'(d[a]);
		always_ff @(posedge clk) begin
			if (en) begin
				n1_s1[a] <= NW'((NW'(lo[a]) - NW'(o[a])) <<< FRAC_BITS);
				n2_s1[a] <= NW'((NW'(hi[a]) - NW'(o[a])) <<< FRAC_BITS);
				d_s1[a] <= d[a];
				o_s1[a] <= o[a];
				par_s1[a] <= (d[a] == '0) || (mg < $signed({1'b0, (CW)'(thr_q)}));
				out_s1[a] <= (o[a] < lo[a]) || (o[a] > hi[a]);
			end
		end
	end

	// dividers plus delay lines for side data
	logic signed [NW-1:0] t1w [3], t2w [3];
	logic [2:0] dl_par [DL], dl_out [DL];
	for (genvar a = 0; a < 3; a++) begin : g_div
		logic signed [CW-1:0] dd;
		assign dd = par_s1[a] ? c_t'(1) : d_s1[a];
		rbsi_div #(.NW(NW), .DW(CW)) u_d1 (.clk, .en, .num(n1_s1[a]), .den(dd), .quo(t1w[a]));
		rbsi_div #(.NW(NW), .DW(CW)) u_d2 (.clk, .en, .num(n2_s1[a]), .den(dd), .quo(t2w[a]));
	end
	logic [CW*3-1:0] dpk, opk;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				dl_par[0][a] <= par_s1[a];
				dl_out[0][a] <= out_s1[a];
			end
			for (int k = 1; k < DL; k++) begin
				dl_par[k] <= dl_par[k-1];
				dl_out[k] <= dl_out[k-1];
			end
		end
	end
	// direction and origin travel as packed words
	logic [CW*3-1:0] dd_q [DL], oo_q [DL];
	assign dpk = {d_s1[0], d_s1[1], d_s1[2]};
	assign opk = {o_s1[0], o_s1[1], o_s1[2]};
	always_ff @(posedge clk) begin
		if (en) begin
			dd_q[0] <= dpk;
			oo_q[0] <= opk;
			for (int k = 1; k < DL; k++) begin
				dd_q[k] <= dd_q[k-1];
				oo_q[k] <= oo_q[k-1];
			end
		end
	end

	// stage A: saturate, order
	c_t lo_a [3], hi_a [3];
	logic [2:0] par_a, out_a;
	logic [CW*3-1:0] d_a, o_a;
	for (genvar a = 0; a < 3; a++) begin : g_sa
		c_t s1, s2;
		assign s1 = (t1w[a] > QMAXW) ? QMAX : (t1w[a] < QMINW) ? ~QMAX : c_t'(t1w[a]);
		assign s2 = (t2w[a] > QMAXW) ? QMAX : (t2w[a] < QMINW) ? ~QMAX : c_t'(t2w[a]);
		always_ff @(posedge clk) begin
			if (en) begin
				lo_a[a] <= (s1 > s2) ? s2 : s1;
				hi_a[a] <= (s1 > s2) ? s1 : s2;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			par_a <= dl_par[DL-1];
			out_a <= dl_out[DL-1];
			d_a <= dd_q[DL-1];
			o_a <= oo_q[DL-1];
		end
	end

	// stage B: running entry/exit over the three axes, in axis order
	c_t tmin_b;
	logic hit_b;
	logic [CW*3-1:0] d_b, o_b;
	always_ff @(posedge clk) begin
		c_t mn, mx;
		logic h;
		mn = '0;
		mx = QMAX;
		h = 1'b1;
		for (int a = 0; a < 3; a++) begin
			if (h) begin
				if (par_a[a]) begin
					if (out_a[a]) h = 1'b0;
				end else begin
					if (lo_a[a] > mn) mn = lo_a[a];
					if (hi_a[a] < mx) mx = hi_a[a];
					if (mn > mx) h = 1'b0;
				end
			end
		end
		if (en) begin
			tmin_b <= mn;
			hit_b <= h;
			d_b <= d_a;
			o_b <= o_a;
		end
	end

	// stage C: products
	logic signed [PW-1:0] p_c [3];
	c_t tmin_c;
	logic hit_c;
	logic [CW*3-1:0] o_c;
	for (genvar a = 0; a < 3; a++) begin : g_sc
		always_ff @(posedge clk) begin
			if (en) p_c[a] <= $signed(d_b[(3-a)*CW-1 -: CW]) * $signed(PW'(tmin_b));
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			tmin_c <= tmin_b;
			hit_c <= hit_b;
			o_c <= o_b;
		end
	end

	// stage D: shift, add, saturate; hit point and entry distance forced to zero on a miss
	c_t hx_d [3];
	c_t tmin_d;
	logic hit_d;
	for (genvar a = 0; a < 3; a++) begin : g_sd
		logic signed [PW:0] sm;
		assign sm = (PW+1)'(p_c[a] >>> FRAC_BITS)
			+ (PW+1)'($signed(o_c[(3-a)*CW-1 -: CW]));
		always_ff @(posedge clk) begin
			if (en) hx_d[a] <= !hit_c ? '0
				: (sm > (PW+1)'(QMAX)) ? QMAX
				: (sm < -(PW+1)'(QMAX) - 1) ? ~QMAX : c_t'(sm);
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			tmin_d <= hit_c ? tmin_c : '0;
			hit_d <= hit_c;
		end
	end

	assign out_ch.valid = v_q[LAT-1];
	assign out_ch.data = {hit_d, tmin_d[CW-2:0], hx_d[0], hx_d[1], hx_d[2]};
endmodule
